>>> rtl/core/klre_pkg.sv
// ----------------------------------------------------------------------------
// klre_pkg: shared types and constants for the keyed record list engine
// Command and status codes, controller state and control struct.
// ----------------------------------------------------------------------------
package klre_pkg;

  localparam int CAPACITY_DEF      = 64;
  localparam int PAYLOAD_WIDTH_DEF = 64;
  localparam int CMD_W             = 4;
  localparam int KEY_W             = 32;
  localparam int POS_W             = 7;
  localparam int STATUS_W          = 3;
  localparam int COUNT_OUT_W       = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND     = 4'd0,
    CMD_PUSH_FRONT = 4'd1,
    CMD_ORD_INSERT = 4'd2,
    CMD_REMOVE_KEY = 4'd3,
    CMD_REMOVE_SWAP = 4'd4,
    CMD_POP_FRONT  = 4'd5,
    CMD_POP_BACK   = 4'd6,
    CMD_READ_POS   = 4'd7,
    CMD_READ_KEY   = 4'd8
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADPOS   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EVAL = 2'd1,
    S_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic load;   // capture input beat, run per-cell compares
    logic exec;   // apply command to cells, register result
  } dp_ctrl_t;

endpackage

>>> rtl/core/klre_ctrl.sv
// ----------------------------------------------------------------------------
// klre_ctrl: command sequencer
// Steps each input beat through compare and execute, then holds the result.
// ----------------------------------------------------------------------------
module klre_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output klre_pkg::dp_ctrl_t  ctrl
);

  klre_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= klre_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      klre_pkg::S_IDLE: begin
        if (in_valid) state_nxt = klre_pkg::S_EVAL;
      end
      klre_pkg::S_EVAL: begin
        state_nxt = klre_pkg::S_DONE;
      end
      klre_pkg::S_DONE: begin
        if (out_ready) state_nxt = klre_pkg::S_IDLE;
      end
      default: state_nxt = klre_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ctrl      = '0;
    case (state_r)
      klre_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      klre_pkg::S_EVAL: begin
        ctrl.exec = 1'b1;
      end
      klre_pkg::S_DONE: begin
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/klre_dp.sv
// ----------------------------------------------------------------------------
// klre_dp: record cell row and result register
// Keys compare in parallel; inserts, key removal and pop-front shift the row.
// ----------------------------------------------------------------------------
module klre_dp #(
  parameter int CAPACITY      = klre_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_WIDTH = klre_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  klre_pkg::dp_ctrl_t                      ctrl,
  input  logic [klre_pkg::CMD_W-1:0]              in_command,
  input  logic signed [klre_pkg::KEY_W-1:0]       in_key,
  input  logic [PAYLOAD_WIDTH-1:0]                in_record_data,
  input  logic [klre_pkg::POS_W-1:0]              in_position,
  output logic [klre_pkg::STATUS_W-1:0]           out_status,
  output logic signed [klre_pkg::KEY_W-1:0]       out_found_key,
  output logic [PAYLOAD_WIDTH-1:0]                out_found_data,
  output logic [klre_pkg::COUNT_OUT_W-1:0]        out_entry_count,
  output logic                                    out_is_full,
  output logic                                    out_is_empty
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > klre_pkg::POS_W) ? CW : klre_pkg::POS_W;

  logic signed [klre_pkg::KEY_W-1:0] cell_key_r  [CAPACITY];
  logic signed [klre_pkg::KEY_W-1:0] cell_key_nxt[CAPACITY];
  logic [PAYLOAD_WIDTH-1:0]          cell_dat_r  [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0]          cell_dat_nxt[CAPACITY];
  logic [CW-1:0]                     count_r, count_nxt;

  logic [klre_pkg::CMD_W-1:0]        cmd_r;
  logic signed [klre_pkg::KEY_W-1:0] key_r;
  logic [PAYLOAD_WIDTH-1:0]          dat_r;
  logic [klre_pkg::POS_W-1:0]        pos_r;
  logic [CAPACITY-1:0]               eq_r, lt_r, vmask_r;
  logic [CAPACITY-1:0]               eq_c, lt_c, vmask_c;

  // per-cell compares at capture time
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      vmask_c[i] = CW'(i) < count_r;
      eq_c[i]    = vmask_c[i] && (cell_key_r[i] == in_key);
      lt_c[i]    = vmask_c[i] && (cell_key_r[i] < in_key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r   <= in_command;
      key_r   <= in_key;
      dat_r   <= in_record_data;
      pos_r   <= in_position;
      eq_r    <= eq_c;
      lt_r    <= lt_c;
      vmask_r <= vmask_c;
    end
    if (ctrl.exec) begin
      cell_key_r <= cell_key_nxt;
      cell_dat_r <= cell_dat_nxt;
    end
  end

  logic [CAPACITY-1:0]               cnt_oh, last_oh, pos_oh, first_oh, ge_v, ord_v;
  logic [CAPACITY-1:0]               ins_oh, above, rm_oh, at_above, sel_oh;
  logic                              is_full_c, is_empty_c, pos_bad;
  logic signed [klre_pkg::KEY_W-1:0] last_k, sel_k;
  logic [PAYLOAD_WIDTH-1:0]          last_d, sel_d;
  logic [EW-1:0]                     pos_e;
  klre_pkg::status_t                 st_c;
  logic                              do_ins, do_close, do_swap, do_rd;

  always_comb begin
    pos_e      = EW'(pos_r);
    is_full_c  = count_r == CW'(CAPACITY);
    is_empty_c = count_r == '0;
    pos_bad    = (pos_e == '0) || (pos_e > EW'(count_r));
    for (int i = 0; i < CAPACITY; i++) begin
      cnt_oh[i] = CW'(i) == count_r;
      pos_oh[i] = EW'(i + 1) == pos_e;
    end
    last_oh  = cnt_oh >> 1;
    if (is_full_c) last_oh[CAPACITY-1] = 1'b1;
    first_oh = eq_r & (~eq_r + 1'b1);
    ge_v     = (~lt_r & vmask_r) | cnt_oh;
    ord_v    = ge_v & (~ge_v + 1'b1);

    st_c     = klre_pkg::ST_OK;
    do_ins   = 1'b0;
    do_close = 1'b0;
    do_swap  = 1'b0;
    do_rd    = 1'b0;
    ins_oh   = '0;
    rm_oh    = first_oh;
    sel_oh   = first_oh;
    count_nxt = count_r;
    case (cmd_r)
      klre_pkg::CMD_APPEND, klre_pkg::CMD_PUSH_FRONT, klre_pkg::CMD_ORD_INSERT: begin
        if (is_full_c) begin
          st_c = klre_pkg::ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + 1'b1;
          if (cmd_r == klre_pkg::CMD_APPEND)          ins_oh = cnt_oh;
          else if (cmd_r == klre_pkg::CMD_PUSH_FRONT) ins_oh = CAPACITY'(1);
          else                                        ins_oh = ord_v;
        end
      end
      klre_pkg::CMD_REMOVE_KEY, klre_pkg::CMD_REMOVE_SWAP: begin
        if (is_empty_c) begin
          st_c = klre_pkg::ST_EMPTY;
        end else if (eq_r == '0) begin
          st_c = klre_pkg::ST_NOTFOUND;
        end else begin
          count_nxt = count_r - 1'b1;
          if (cmd_r == klre_pkg::CMD_REMOVE_KEY) do_close = 1'b1;
          else                                   do_swap  = 1'b1;
        end
      end
      klre_pkg::CMD_POP_FRONT: begin
        if (is_empty_c) begin
          st_c = klre_pkg::ST_EMPTY;
        end else begin
          rm_oh     = CAPACITY'(1);
          do_close  = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      klre_pkg::CMD_POP_BACK: begin
        if (is_empty_c) st_c = klre_pkg::ST_EMPTY;
        else            count_nxt = count_r - 1'b1;
      end
      klre_pkg::CMD_READ_POS: begin
        sel_oh = pos_oh;
        if (pos_bad) st_c = klre_pkg::ST_BADPOS;
        else         do_rd = 1'b1;
      end
      klre_pkg::CMD_READ_KEY: begin
        if (eq_r == '0) st_c = klre_pkg::ST_NOTFOUND;
        else            do_rd = 1'b1;
      end
      default: ;
    endcase

    above    = ~(ins_oh - 1'b1) & ~ins_oh;
    at_above = ~(rm_oh - 1'b1);

    // one-hot selects across the row
    last_k = '0;
    last_d = '0;
    sel_k  = '0;
    sel_d  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (last_oh[i]) begin
        last_k = last_k | cell_key_r[i];
        last_d = last_d | cell_dat_r[i];
      end
      if (sel_oh[i]) begin
        sel_k = sel_k | cell_key_r[i];
        sel_d = sel_d | cell_dat_r[i];
      end
    end

    for (int i = 0; i < CAPACITY; i++) begin
      cell_key_nxt[i] = cell_key_r[i];
      cell_dat_nxt[i] = cell_dat_r[i];
      if (do_ins) begin
        if (ins_oh[i]) begin
          cell_key_nxt[i] = key_r;
          cell_dat_nxt[i] = dat_r;
        end else if (above[i] && i > 0) begin
          cell_key_nxt[i] = cell_key_r[(i > 0) ? i - 1 : 0];
          cell_dat_nxt[i] = cell_dat_r[(i > 0) ? i - 1 : 0];
        end
      end
      if (do_close && at_above[i] && i < CAPACITY - 1) begin
        cell_key_nxt[i] = cell_key_r[(i < CAPACITY - 1) ? i + 1 : i];
        cell_dat_nxt[i] = cell_dat_r[(i < CAPACITY - 1) ? i + 1 : i];
      end
      if (do_swap && first_oh[i]) begin
        cell_key_nxt[i] = last_k;
        cell_dat_nxt[i] = last_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      out_status      <= st_c;
      out_found_key   <= do_rd ? sel_k : '0;
      out_found_data  <= do_rd ? sel_d : '0;
      out_entry_count <= klre_pkg::COUNT_OUT_W'(count_nxt);
      out_is_full     <= count_nxt == CW'(CAPACITY);
      out_is_empty    <= count_nxt == '0;
    end
  end

endmodule

>>> rtl/core/keyed_record_list_engine.sv
// ----------------------------------------------------------------------------
// keyed_record_list_engine: fixed-capacity ordered list of keyed records
// Top level: sequencer plus record cell row.
// ----------------------------------------------------------------------------
// Each command steps through the sequencer states in order: in IDLE the beat
// is captured and the per-cell key compares are registered; in EVAL the
// cell row is shifted or selected and the result registered; in DONE the
// result is presented until the receiver takes it. The next beat is taken the
// cycle after the result beat leaves, so no new command is accepted while
// one is in flight. Cells hold CAPACITY records in registers, so inserts,
// remove-key and pop-front shift the whole row in one step. No clearing pass
// is needed after reset; only the count and the sequencer state reset.
module keyed_record_list_engine #(
  parameter int CAPACITY      = klre_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_WIDTH = klre_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [klre_pkg::CMD_W-1:0]          in_command,
  input  logic signed [klre_pkg::KEY_W-1:0]   in_key,
  input  logic [PAYLOAD_WIDTH-1:0]            in_record_data,
  input  logic [klre_pkg::POS_W-1:0]          in_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [klre_pkg::STATUS_W-1:0]       out_status,
  output logic signed [klre_pkg::KEY_W-1:0]   out_found_key,
  output logic [PAYLOAD_WIDTH-1:0]            out_found_data,
  output logic [klre_pkg::COUNT_OUT_W-1:0]    out_entry_count,
  output logic                                out_is_full,
  output logic                                out_is_empty
);

  klre_pkg::dp_ctrl_t ctrl;

  klre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  klre_dp #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_record_data  (in_record_data),
    .in_position     (in_position),
    .out_status      (out_status),
    .out_found_key   (out_found_key),
    .out_found_data  (out_found_data),
    .out_entry_count (out_entry_count),
    .out_is_full     (out_is_full),
    .out_is_empty    (out_is_empty)
  );

endmodule
